[hdl/snfr_pkg.sv]
package snfr_pkg;

   localparam int MAX_FRAME = 256;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);
   localparam int WIDE_W    = (CNT_W > 8) ? CNT_W : 8;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);

   localparam logic [7:0]  SLIP_END     = 8'hC0;
   localparam logic [7:0]  SLIP_ESC     = 8'hDB;
   localparam logic [7:0]  SLIP_ESC_END = 8'hDC;
   localparam logic [7:0]  SLIP_ESC_ESC = 8'hDD;
   localparam logic [15:0] CRC_POLY     = 16'h8408;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;

   localparam int HDR_BYTES = 3;
   localparam int MIN_FRAME = 5;

   localparam logic       KIND_PAYLOAD = 1'b0;
   localparam logic       KIND_STATUS  = 1'b1;
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CRC   = 2'd1;
   localparam logic [1:0] STATUS_SHORT = 2'd2;

   typedef enum logic {
      ST_HUNT,
      ST_FRAME
   } rx_state_type;

   // decoded request passed from the front to the back
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } event_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic [7:0]  d;
      logic        fb;
      c = crc;
      d = b;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ d[0];
         c  = c >> 1;
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

[hdl/snfr_front.sv]
module snfr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                q_full,
   output logic                q_push,
   output snfr_pkg::event_type q_event
);
   import snfr_pkg::*;

   rx_state_type     state_ff, state_in;
   logic             escape_ff, escape_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             at_limit;
   logic [7:0]       unescaped;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign at_limit   = count_ff >= CNT_W'(MAX_FRAME);

   always_comb begin
      case (req_tdata)
         SLIP_ESC_END: unescaped = SLIP_END;
         SLIP_ESC_ESC: unescaped = SLIP_ESC;
         default:      unescaped = req_tdata;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HUNT: begin
            if (accept && req_tdata == SLIP_END) state_in = ST_FRAME;
         end
         ST_FRAME: begin
            if (accept && req_tdata == SLIP_END) state_in = ST_HUNT;
         end
         default: state_in = ST_HUNT;
      endcase
   end

   always_comb begin
      q_push    = 1'b0;
      q_event   = '{is_end: 1'b0, data: req_tdata};
      escape_in = escape_ff;
      count_in  = count_ff;
      case (state_ff)
         ST_HUNT: begin
            if (accept && req_tdata == SLIP_END) begin
               escape_in = 1'b0;
               count_in  = '0;
            end
         end
         ST_FRAME: begin
            if (accept) begin
               if (req_tdata == SLIP_END) begin
                  q_push         = 1'b1;
                  q_event.is_end = 1'b1;
                  escape_in      = 1'b0;
               end else if (escape_ff) begin
                  escape_in = 1'b0;
                  if (!at_limit) begin
                     q_push       = 1'b1;
                     q_event.data = unescaped;
                     count_in     = count_ff + 1'b1;
                  end
               end else if (at_limit) begin
                  // drop bytes past the frame limit
                  count_in = count_ff;
               end else if (req_tdata == SLIP_ESC) begin
                  escape_in = 1'b1;
               end else begin
                  q_push   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: begin
            escape_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HUNT;
         escape_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         escape_ff <= escape_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/snfr_queue.sv]
module snfr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  snfr_pkg::event_type push_event,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output snfr_pkg::event_type pop_event
);
   import snfr_pkg::*;

   event_type          slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full      = fill_ff == (Q_PTR_W + 1)'(Q_DEPTH);
   assign not_empty = fill_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_event = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fill_ff <= fill_in;
      end
   end

endmodule

[hdl/snfr_back.sv]
module snfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                evt_valid,
   input  snfr_pkg::event_type evt,
   output logic                evt_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [55:0]         rsp_tdata,
   output logic                rsp_tuser
);
   import snfr_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        delay0_ff, delay0_in, delay1_ff, delay1_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        hdr_ff [HDR_BYTES];
   logic [7:0]        hdr_in [HDR_BYTES];
   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [7:0]        byte_ff, byte_in, index_ff, index_in, len_ff, len_in;
   logic [1:0]        status_ff, status_in;
   logic [7:0]        src_ff, dst_ff, ctl_ff;
   logic [WIDE_W-1:0] count_wide, less_min;
   logic              short_frame;

   assign evt_pop     = evt_valid && (!valid_ff || rsp_tready);
   assign count_wide  = WIDE_W'(count_ff);
   assign less_min    = count_wide - WIDE_W'(MIN_FRAME);
   assign short_frame = count_ff < CNT_W'(MIN_FRAME);

   always_comb begin
      count_in  = count_ff;
      delay0_in = delay0_ff;
      delay1_in = delay1_ff;
      crc_in    = crc_ff;
      hdr_in    = hdr_ff;
      valid_in  = valid_ff && !rsp_tready;
      kind_in   = KIND_PAYLOAD;
      byte_in   = '0;
      index_in  = '0;
      status_in = STATUS_OK;
      len_in    = '0;
      if (evt_pop) begin
         if (evt.is_end) begin
            valid_in = 1'b1;
            kind_in  = KIND_STATUS;
            if (short_frame) begin
               status_in = STATUS_SHORT;
            end else begin
               status_in = ({delay1_ff, delay0_ff} == crc_ff) ? STATUS_OK : STATUS_CRC;
               len_in    = less_min[7:0];
            end
            // start the next frame clean
            count_in  = '0;
            delay0_in = '0;
            delay1_in = '0;
            crc_in    = CRC_INIT;
            for (int i = 0; i < HDR_BYTES; i++) hdr_in[i] = '0;
         end else begin
            count_in = count_ff + 1'b1;
            if (count_ff < CNT_W'(HDR_BYTES)) begin
               hdr_in[count_ff[1:0]] = evt.data;
               crc_in                = crc_byte(crc_ff, evt.data);
            end else begin
               if (!short_frame) begin
                  crc_in   = crc_byte(crc_ff, delay0_ff);
                  valid_in = 1'b1;
                  byte_in  = delay0_ff;
                  index_in = less_min[7:0];
               end
               delay0_in = delay1_ff;
               delay1_in = evt.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         count_ff  <= '0;
         delay0_ff <= '0;
         delay1_ff <= '0;
         crc_ff    <= CRC_INIT;
         for (int i = 0; i < HDR_BYTES; i++) hdr_ff[i] <= '0;
      end else begin
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         delay0_ff <= delay0_in;
         delay1_ff <= delay1_in;
         crc_ff    <= crc_in;
         hdr_ff    <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt_pop) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         index_ff  <= index_in;
         status_ff <= status_in;
         len_ff    <= len_in;
         src_ff    <= hdr_ff[0];
         dst_ff    <= hdr_ff[1];
         ctl_ff    <= hdr_ff[2];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {6'b0, len_ff, ctl_ff, dst_ff, src_ff, status_ff, index_ff, byte_ff};

endmodule

[hdl/slip_nsp_frame_receiver.sv]
// SLIP frame receiver with CRC-16 check.
// Request channel (req_): one raw serial byte per request in req_tdata[7:0].
// Result channel (rsp_): rsp_tuser is the kind, 0 for a payload byte and 1 for
// the end-of-frame status; rsp_tdata carries byte, index, status, the three
// header bytes and the payload length.
// Throughput: one request per cycle while the queue has room, in every state. A
// byte that yields a result reaches rsp_ through the queue and the result register:
// the front decodes it and writes it into the four-entry queue at the accepting
// edge, and the back pops it into its result register once that register is free.
// The back stage runs one CRC byte update per cycle while requests are popped;
// that unrolled update and the compare at frame end set the clock path.
// Reset clears the decoder to hunting for a delimiter, empties the queue and
// drops any pending result; no clearing pass is needed.
// When the receiver stalls rsp_tready, the result register holds, the queue
// fills with up to four decoded requests, and then req_tready drops until
// room returns. No request is lost or repeated.
// Payload bytes are released before the CRC is checked: treat them as
// tentative until the status result arrives.
module slip_nsp_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // [7:0] payload_byte, [15:8] payload_index,
                                   // [17:16] frame_status, [25:18] reply_source,
                                   // [33:26] reply_destination, [41:34] control_field,
                                   // [49:42] payload_length, [55:50] zero
   output logic        rsp_tuser   // [0] kind
);
   import snfr_pkg::*;

   // decoded requests between the front and the back
   event_type push_event, pop_event;
   logic      q_push, q_full, q_pop, q_not_empty;

   // hunt, unescape and enforce the frame limit
   snfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_event    (push_event)
   );

   // decouple decoding from result delivery
   snfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_event (push_event),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_event  (pop_event)
   );

   // latch the header, delay the payload by two bytes, run the CRC, report
   snfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .evt_valid  (q_not_empty),
      .evt        (pop_event),
      .evt_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[hdl/snfr_checker.sv]
module snfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);
   import snfr_pkg::*;

   logic req_seen;
   assign req_seen = req_tvalid && req_tready && (req_tdata == SLIP_END);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PAYLOAD |->
         rsp_tdata[17:16] == STATUS_OK && rsp_tdata[49:42] == 8'd0)
      else $error("payload result carries status fields");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |->
         rsp_tdata[15:0] == 16'd0 && rsp_tdata[17:16] != 2'd3 &&
         (rsp_tdata[17:16] != STATUS_SHORT || rsp_tdata[49:42] == 8'd0))
      else $error("malformed status result");

   a_no_early: assert property (@(posedge clock)
      $past(reset) && !reset && !req_seen |=> !rsp_tvalid)
      else $error("result without a delimited frame");

endmodule

bind slip_nsp_frame_receiver snfr_checker u_snfr_checker (.*);

[dv/tb_slip_nsp_frame_receiver.sv]
module tb_slip_nsp_frame_receiver;
   import snfr_pkg::*;

   // run length: counted requests, the quiet tail, the receiver hold-off and a hard stop
   localparam int ITEMS_TARGET = 850;
   localparam int CALM_ITEMS   = 120;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT      = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int N_DIRECTED   = 24;

   // one result of the block, split into its fields
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] index;
      logic [1:0] status;
      logic [7:0] source;
      logic [7:0] dest;
      logic [7:0] control;
      logic [7:0] length;
   } rx_result_type;

   // a directed request, with its result typed in where it is obvious
   typedef struct packed {
      logic [7:0]    rx;
      logic          typed;
      rx_result_type result;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // [7:0] payload_byte, [15:8] payload_index, [17:16] frame_status,
                             // [25:18] reply_source, [33:26] reply_destination,
                             // [41:34] control_field, [49:42] payload_length, [55:50] zero
   logic        rsp_tuser;   // [0] kind

   // deframer state as the predictor sees it
   bit          frame_hunting = 1'b1;
   bit          esc_armed     = 1'b0;
   int          byte_count    = 0;
   logic [7:0]  tail_bytes [2] = '{8'h00, 8'h00};
   logic [15:0] crc_acc       = CRC_INIT;
   logic [7:0]  hdr_bytes [3] = '{8'h00, 8'h00, 8'h00};

   rx_result_type expected_results [$];
   int          predicted_count = 0;
   int          mismatch_count  = 0;
   int          items_sent      = 0;
   int          cycle_count     = 0;
   bit          calm            = 1'b0;
   bit          held_off        = 1'b0;

   directed_row_type directed_rows [N_DIRECTED];

   slip_nsp_frame_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // reflected CRC-16: fold the byte into the low end, then shift out eight bits
   function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic rx_result_type make_result(input logic kind, input logic [7:0] data,
                                                 input logic [7:0] index,
                                                 input logic [1:0] status,
                                                 input logic [7:0] source,
                                                 input logic [7:0] dest,
                                                 input logic [7:0] control,
                                                 input logic [7:0] length);
      rx_result_type r;
      r = '{kind, data, index, status, source, dest, control, length};
      return r;
   endfunction

   // biased byte: SLIP specials turn up often so escapes get exercised
   function automatic logic [7:0] pick_byte();
      logic [7:0] specials [4];
      specials = '{SLIP_END, SLIP_ESC, SLIP_ESC_END, SLIP_ESC_ESC};
      if ($urandom_range(0, 4) == 0) return specials[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic rx_result_type header_fields();
      rx_result_type r;
      r = '0;
      r.source  = hdr_bytes[0];
      r.dest    = hdr_bytes[1];
      r.control = hdr_bytes[2];
      return r;
   endfunction

   // store one decoded byte: latch the header, else push through the two-byte delay
   task automatic store_decoded(input logic [7:0] d);
      rx_result_type r;
      if (byte_count >= MAX_FRAME) return;
      if (byte_count < HDR_BYTES) begin
         hdr_bytes[byte_count] = d;
         crc_acc = crc16_update(crc_acc, d);
      end else begin
         if (byte_count >= MIN_FRAME) begin
            crc_acc = crc16_update(crc_acc, tail_bytes[0]);
            r = header_fields();
            r.kind  = KIND_PAYLOAD;
            r.data  = tail_bytes[0];
            r.index = 8'(byte_count - MIN_FRAME);
            expected_results.push_back(r);
            predicted_count++;
         end
         tail_bytes[0] = tail_bytes[1];
         tail_bytes[1] = d;
      end
      byte_count++;
   endtask

   // advance the predictor by one accepted request
   task automatic predict_byte(input logic [7:0] b);
      rx_result_type r;
      logic [7:0] d;
      if (frame_hunting) begin
         if (b == SLIP_END) begin
            frame_hunting = 1'b0;
            esc_armed     = 1'b0;
            byte_count    = 0;
            tail_bytes    = '{8'h00, 8'h00};
            crc_acc       = CRC_INIT;
            hdr_bytes     = '{8'h00, 8'h00, 8'h00};
         end
         return;
      end
      if (b == SLIP_END) begin
         r = header_fields();
         r.kind = KIND_STATUS;
         if (byte_count < MIN_FRAME) begin
            r.status = STATUS_SHORT;
         end else begin
            r.status = ({tail_bytes[1], tail_bytes[0]} == crc_acc) ? STATUS_OK : STATUS_CRC;
            r.length = 8'(byte_count - MIN_FRAME);
         end
         expected_results.push_back(r);
         predicted_count++;
         esc_armed     = 1'b0;
         frame_hunting = 1'b1;
         return;
      end
      if (esc_armed) begin
         esc_armed = 1'b0;
         d = (b == SLIP_ESC_END) ? SLIP_END : (b == SLIP_ESC_ESC) ? SLIP_ESC : b;
         store_decoded(d);
         return;
      end
      if (byte_count >= MAX_FRAME) return;
      if (b == SLIP_ESC) begin
         esc_armed = 1'b1;
         return;
      end
      store_decoded(b);
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("[%0d] %s: got %02h, want %02h", cycle_count, what, got, want);
   endtask

   // offer one request, with an occasional idle burst first; keep tvalid high afterwards
   task automatic send_byte(input logic [7:0] b);
      bit counted;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // bytes dropped while hunting do not count toward the run length
      counted = !frame_hunting || (b == SLIP_END);
      predict_byte(b);
      if (counted) items_sent++;
      calm = items_sent >= ITEMS_TARGET - CALM_ITEMS;
   endtask

   // hold the request side quiet until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock);
      while (expected_results.size() != 0);
   endtask

   // build one frame with a good CRC, escape it, then maybe break it on purpose
   task automatic send_random_frame(input int payload_len);
      logic [7:0]  body [$];
      logic [7:0]  raw [$];
      logic [15:0] crc;
      logic [7:0]  x;
      int          mode;
      int          p;
      crc = CRC_INIT;
      for (int i = 0; i < HDR_BYTES + payload_len; i++) begin
         body.push_back(pick_byte());
         crc = crc16_update(crc, body[i]);
      end
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      mode = $urandom_range(0, 11);
      // truncated frame: cut to four bytes or fewer, always too short
      if (mode == 1) begin
         p = $urandom_range(0, 4);
         while (body.size() > p) void'(body.pop_back());
      end
      raw.push_back(SLIP_END);
      foreach (body[i]) begin
         if (body[i] == SLIP_END) begin
            raw.push_back(SLIP_ESC);
            raw.push_back(SLIP_ESC_END);
         end else if (body[i] == SLIP_ESC) begin
            raw.push_back(SLIP_ESC);
            raw.push_back(SLIP_ESC_ESC);
         end else begin
            raw.push_back(body[i]);
         end
      end
      case (mode)
         0: begin
            // flip one bit somewhere after the opener
            if (raw.size() > 1) begin
               p = $urandom_range(1, raw.size() - 1);
               raw[p] = raw[p] ^ (8'h01 << $urandom_range(0, 7));
            end
         end
         2: begin
            // escape followed by an ordinary byte: kept as it is
            do x = 8'($urandom_range(0, 255));
            while (x == SLIP_END || x == SLIP_ESC_END || x == SLIP_ESC_ESC);
            p = $urandom_range(1, raw.size());
            raw.insert(p, x);
            raw.insert(p, SLIP_ESC);
         end
         3: raw.push_back(SLIP_ESC);   // escape dangling at the closing delimiter
         default: ;
      endcase
      raw.push_back(SLIP_END);
      foreach (raw[i]) send_byte(raw[i]);
   endtask

   // receiver side: random stalls, one long hold-off while requests keep coming
   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         if (!held_off && items_sent >= HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held_off = 1'b1;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // check every accepted result against the oldest expectation
   always @(posedge clock) begin : check_results
      rx_result_type got;
      rx_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = make_result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[17:16],
                           rsp_tdata[25:18], rsp_tdata[33:26], rsp_tdata[41:34],
                           rsp_tdata[49:42]);
         if (rsp_tdata[55:50] != '0)
            report_mismatch("padding", {2'b00, rsp_tdata[55:50]}, 8'h00);
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending", {7'd0, got.kind}, 8'h00);
         end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind)
               report_mismatch("kind", {7'd0, got.kind}, {7'd0, want.kind});
            if (got.data != want.data) report_mismatch("payload_byte", got.data, want.data);
            if (got.index != want.index)
               report_mismatch("payload_index", got.index, want.index);
            if (got.status != want.status)
               report_mismatch("frame_status", {6'd0, got.status}, {6'd0, want.status});
            if (got.source != want.source)
               report_mismatch("reply_source", got.source, want.source);
            if (got.dest != want.dest)
               report_mismatch("reply_destination", got.dest, want.dest);
            if (got.control != want.control)
               report_mismatch("control_field", got.control, want.control);
            if (got.length != want.length)
               report_mismatch("payload_length", got.length, want.length);
         end
      end
   end

   // hard stop in case the block wedges
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int n;
      int frame_no;
      int len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;

      directed_rows = '{
         '{8'h55, 1'b0, rx_result_type'('0)},   // dropped while hunting
         '{8'hFF, 1'b0, rx_result_type'('0)},   // dropped while hunting
         '{SLIP_END, 1'b0, rx_result_type'('0)},
         // two delimiters in a row: empty frame, too short
         '{SLIP_END, 1'b1, make_result(KIND_STATUS, 8'h00, 8'h00, STATUS_SHORT,
                                       8'h00, 8'h00, 8'h00, 8'h00)},
         '{SLIP_END, 1'b0, rx_result_type'('0)},
         '{8'h00, 1'b0, rx_result_type'('0)},
         '{8'hFF, 1'b0, rx_result_type'('0)},
         '{SLIP_END, 1'b1, make_result(KIND_STATUS, 8'h00, 8'h00, STATUS_SHORT,
                                       8'h00, 8'hFF, 8'h00, 8'h00)},
         '{SLIP_END, 1'b0, rx_result_type'('0)},
         '{SLIP_ESC, 1'b0, rx_result_type'('0)},
         '{SLIP_ESC_END, 1'b0, rx_result_type'('0)},   // source C0
         '{SLIP_ESC, 1'b0, rx_result_type'('0)},
         '{SLIP_ESC_ESC, 1'b0, rx_result_type'('0)},   // destination DB
         '{SLIP_ESC, 1'b0, rx_result_type'('0)},
         '{8'h41, 1'b0, rx_result_type'('0)},          // bad escape, control 41
         '{8'hFF, 1'b0, rx_result_type'('0)},
         '{8'h00, 1'b0, rx_result_type'('0)},
         // sixth stored byte releases the first payload byte
         '{8'h7E, 1'b1, make_result(KIND_PAYLOAD, 8'hFF, 8'h00, STATUS_OK,
                                    8'hC0, 8'hDB, 8'h41, 8'h00)},
         '{SLIP_ESC, 1'b0, rx_result_type'('0)},
         '{SLIP_END, 1'b0, rx_result_type'('0)},       // delimiter after escape ends it
         '{SLIP_END, 1'b0, rx_result_type'('0)},
         '{SLIP_ESC, 1'b0, rx_result_type'('0)},
         '{8'h00, 1'b0, rx_result_type'('0)},
         '{SLIP_END, 1'b1, make_result(KIND_STATUS, 8'h00, 8'h00, STATUS_SHORT,
                                       8'h00, 8'h00, 8'h00, 8'h00)}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows replace whatever the predictor queued
      foreach (directed_rows[i]) begin
         n = predicted_count;
         send_byte(directed_rows[i].rx);
         if (directed_rows[i].typed) begin
            if (predicted_count > n) void'(expected_results.pop_back());
            expected_results.push_back(directed_rows[i].result);
         end
      end
      drain_results();

      // random frames: mostly small, one exactly full, one past the limit, a few large
      frame_no = 0;
      while (items_sent < ITEMS_TARGET) begin
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
         if (frame_no == 2) len = MAX_FRAME - MIN_FRAME;
         else if (frame_no == 3) len = MAX_FRAME + 6;
         else if ($urandom_range(0, 59) == 0) len = $urandom_range(240, 270);
         else len = $urandom_range(0, 24);
         send_random_frame(len);
         frame_no++;
         if (frame_no == 10) drain_results();
      end

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[slip_nsp_frame_receiver.f]
hdl/snfr_pkg.sv
hdl/snfr_front.sv
hdl/snfr_queue.sv
hdl/snfr_back.sv
hdl/slip_nsp_frame_receiver.sv
hdl/snfr_checker.sv
dv/tb_slip_nsp_frame_receiver.sv
